[design/wlse_pkg.sv]
package wlse_pkg;

    // Fixed-point constants in Q30.
    localparam logic [30:0] Q30_ONE   = 31'd1073741824;
    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [29:0] LN2_Q30   = 30'd744261118;

    // Reciprocals are ceil(2^RECIP_SHIFT / d); exact for the operand ranges used here.
    localparam int RECIP_SHIFT = 34;

    // Result status codes.
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_SUM_ZERO = 2'd1;
    localparam logic [1:0] STAT_OVERFLOW = 2'd2;

    // Reciprocal of the Taylor term index n, for n from 1 to 12.
    function automatic logic [34:0] exp_recip(input logic [3:0] n);
        logic [34:0] r;
        unique case (n)
            4'd1:    r = 35'd17179869184;
            4'd2:    r = 35'd8589934592;
            4'd3:    r = 35'd5726623062;
            4'd4:    r = 35'd4294967296;
            4'd5:    r = 35'd3435973837;
            4'd6:    r = 35'd2863311531;
            4'd7:    r = 35'd2454267027;
            4'd8:    r = 35'd2147483648;
            4'd9:    r = 35'd1908874354;
            4'd10:   r = 35'd1717986919;
            4'd11:   r = 35'd1561806290;
            4'd12:   r = 35'd1431655766;
            default: r = 35'd17179869184;
        endcase
        return r;
    endfunction

    // Reciprocal of the odd divisor 2k+1 of the atanh series, for k from 0 to 14.
    function automatic logic [34:0] ln_recip(input logic [3:0] k);
        logic [34:0] r;
        unique case (k)
            4'd0:    r = 35'd17179869184;
            4'd1:    r = 35'd5726623062;
            4'd2:    r = 35'd3435973837;
            4'd3:    r = 35'd2454267027;
            4'd4:    r = 35'd1908874354;
            4'd5:    r = 35'd1561806290;
            4'd6:    r = 35'd1321528399;
            4'd7:    r = 35'd1145324613;
            4'd8:    r = 35'd1010580541;
            4'd9:    r = 35'd904203642;
            4'd10:   r = 35'd818089009;
            4'd11:   r = 35'd746950835;
            4'd12:   r = 35'd687194768;
            4'd13:   r = 35'd636291452;
            4'd14:   r = 35'd592409283;
            default: r = 35'd17179869184;
        endcase
        return r;
    endfunction

endpackage

[design/wlse_front.sv]
module wlse_front
    import wlse_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int CNT_W = 11
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  logic signed [31:0]   value,
    input  logic [31:0]          weight,
    input  logic                 last,
    input  logic                 q_full,
    input  logic                 q_empty,
    input  logic                 back_idle,
    input  logic [CNT_W-1:0]     rd_ptr,
    output logic                 wr_en,
    output logic [AW-1:0]        wr_addr,
    output logic [63:0]          wr_data,
    output logic                 push,
    output logic [CNT_W+32:0]    push_data
);

    logic [CNT_W-1:0]   count_reg, count_next;
    logic signed [31:0] max_reg, max_next;
    logic               ovf_reg, ovf_next;
    logic               vec_full;
    logic               write_ok;
    logic               accept;
    logic [CNT_W-1:0]   count_inc;
    logic signed [31:0] max_upd;
    logic               ovf_upd;

    // A new entry may only overwrite slots the back end has already read.
    assign vec_full   = (count_reg == CNT_W'(DEPTH));
    assign write_ok   = vec_full || (q_empty && (back_idle || (count_reg < rd_ptr)));
    assign item_ready = write_ok && !q_full;
    assign accept     = item_valid && item_ready;

    // Store the item unless the vector is already full.
    assign wr_en   = accept && !vec_full;
    assign wr_addr = count_reg[AW-1:0];
    assign wr_data = {value, weight};

    // Running maximum, count and overflow flag including this item.
    assign count_inc = vec_full ? count_reg : count_reg + CNT_W'(1);
    assign max_upd   = (!vec_full && (value > max_reg)) ? value : max_reg;
    assign ovf_upd   = ovf_reg || vec_full;

    // The last item hands a job to the back end and clears the vector state.
    assign push      = accept && last;
    assign push_data = {count_inc, max_upd, ovf_upd};

    always_comb
    begin
        count_next = count_reg;
        max_next   = max_reg;
        ovf_next   = ovf_reg;
        if (accept)
        begin
            if (last)
            begin
                count_next = '0;
                max_next   = 32'sh8000_0000;
                ovf_next   = 1'b0;
            end
            else
            begin
                count_next = count_inc;
                max_next   = max_upd;
                ovf_next   = ovf_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            max_reg   <= 32'sh8000_0000;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            max_reg   <= max_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

[design/wlse_queue.sv]
module wlse_queue
#(
    parameter int W = 44
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    input  logic         pop,
    output logic [W-1:0] pop_data,
    output logic         full,
    output logic         empty
);

    logic [W-1:0] slot_reg [2];
    logic         wp_reg, wp_next;
    logic         rp_reg, rp_next;
    logic [1:0]   cnt_reg, cnt_next;

    assign full     = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign pop_data = slot_reg[rp_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (push && !full)
        begin
            wp_next  = ~wp_reg;
        end
        if (pop && !empty)
        begin
            rp_next  = ~rp_reg;
        end
        if ((push && !full) && !(pop && !empty))
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (!(push && !full) && (pop && !empty))
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // Job storage holds payload only.
    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            slot_reg[wp_reg] <= push_data;
        end
    end

endmodule

[design/wlse_back.sv]
module wlse_back
    import wlse_pkg::*;
#(
    parameter int DEPTH     = 1024,
    parameter int FRAC_BITS = 16,
    parameter int AW        = 10,
    parameter int CNT_W     = 11
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  logic [63:0]          wr_data,
    input  logic                 q_empty,
    input  logic [CNT_W+32:0]    job_data,
    output logic                 pop,
    output logic                 back_idle,
    output logic [CNT_W-1:0]     rd_ptr,
    output logic                 result_valid,
    input  logic                 result_ready,
    output logic signed [31:0]   log_sum,
    output logic [1:0]           status
);

    localparam int ACC_W = 33 + AW;
    localparam int SH_W  = $clog2(ACC_W);
    localparam int E_W   = FRAC_BITS + 1;
    localparam int RS    = 30 - FRAC_BITS;
    localparam logic [32:0] EXP_LIMIT = 33'(64) << FRAC_BITS;

    typedef enum logic [4:0] {
        S_IDLE, S_RD, S_DIFF, S_U, S_X, S_T1, S_T2, S_T3, S_SH, S_W, S_ACC,
        S_LCHK, S_NORM, S_DIVINIT, S_DIV, S_Z2, S_LK1, S_LK2, S_V, S_R, S_FIN
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic signed [31:0] max_reg;
    logic               ovf_reg;

    logic [63:0]        mem [DEPTH];
    logic [63:0]        rd_data_reg;
    logic signed [31:0] rd_val;
    logic [31:0]        rd_wt;

    // Exponential unit registers.
    logic [30:0]        d_reg;
    logic               zero_reg;
    logic [30:0]        u_reg;
    logic [6:0]         k_reg;
    logic [29:0]        x_reg;
    logic [30:0]        tsum_reg;
    logic [30:0]        term_reg;
    logic [29:0]        tprod_reg;
    logic [3:0]         n_reg;
    logic [E_W-1:0]     e_reg;
    logic [32:0]        wprod_reg;
    logic [ACC_W-1:0]   acc_reg;

    // Logarithm unit registers.
    logic [ACC_W-1:0]   norm_reg;
    logic [SH_W-1:0]    shifts_reg;
    logic [31:0]        den_reg;
    logic [31:0]        rem_reg;
    logic [30:0]        nlow_reg;
    logic [30:0]        quot_reg;
    logic [4:0]         dcnt_reg;
    logic [29:0]        z2_reg;
    logic [29:0]        pw_reg;
    logic [29:0]        lq_reg;
    logic [31:0]        accl_reg;
    logic [3:0]         lk_reg;
    logic signed [39:0] v_reg;
    logic signed [31:0] res_reg;
    logic               zero_sum_reg;

    logic               result_valid_reg;
    logic signed [31:0] log_sum_reg;
    logic [1:0]         status_reg;

    // Combinational helpers for the step of each state.
    logic signed [32:0] diff_w;
    logic [29:0]        f30_w;
    logic [7:0]         sh_w;
    logic [31:0]        sh_sum_w;
    logic [30:0]        m_w;
    logic [29:0]        mdiff_w;
    logic [32:0]        rem2_w;
    logic [7:0]         pe_w;
    logic signed [39:0] pe_ext_w;
    logic signed [39:0] vprod_w;
    logic [39:0]        mag_w;
    logic [39:0]        r_w;
    logic signed [39:0] res_w;

    assign rd_val = rd_data_reg[63:32];
    assign rd_wt  = rd_data_reg[31:0];

    assign diff_w   = {max_reg[31], max_reg} - {rd_val[31], rd_val};
    assign f30_w    = 30'(u_reg[FRAC_BITS-1:0]) << RS;
    assign sh_w     = 8'(RS) + {1'b0, k_reg};
    assign sh_sum_w = {1'b0, tsum_reg} + (32'd1 << (sh_w - 8'd1));
    assign m_w      = norm_reg[ACC_W-1 -: 31];
    assign mdiff_w  = 30'(m_w - Q30_ONE);
    assign rem2_w   = {rem_reg, nlow_reg[30]};
    assign pe_w     = 8'(ACC_W - 1) - 8'(shifts_reg) - 8'(FRAC_BITS);
    assign pe_ext_w = {{32{pe_w[7]}}, pe_w};
    assign vprod_w  = pe_ext_w * $signed({10'b0, LN2_Q30});
    assign mag_w    = v_reg[39] ? 40'(-v_reg) : 40'(v_reg);
    assign r_w      = (mag_w + (40'd1 << (RS - 1))) >> RS;
    assign res_w    = (v_reg[39] ? -$signed(r_w) : $signed(r_w))
                      + {{8{max_reg[31]}}, max_reg};

    assign pop          = (state_reg == S_IDLE) && !q_empty;
    assign back_idle    = (state_reg == S_IDLE);
    assign rd_ptr       = rd_ptr_reg;
    assign result_valid = result_valid_reg;
    assign log_sum      = log_sum_reg;
    assign status       = status_reg;

    // Vector store: one write port from the front end, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (state_reg == S_RD)
        begin
            rd_data_reg <= mem[rd_ptr_reg[AW-1:0]];
        end
    end

    // Sequencer for the accumulation pass and the logarithm.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            rd_ptr_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            // In the final state a taken result is replaced by the new one below.
            if (result_valid_reg && result_ready && (state_reg != S_FIN))
            begin
                result_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        cnt_reg    <= job_data[CNT_W+32:33];
                        max_reg    <= job_data[32:1];
                        ovf_reg    <= job_data[0];
                        rd_ptr_reg <= '0;
                        acc_reg    <= '0;
                        state_reg  <= (job_data[CNT_W+32:33] == '0) ? S_LCHK : S_RD;
                    end
                end
                S_RD:
                begin
                    rd_ptr_reg <= rd_ptr_reg + CNT_W'(1);
                    state_reg  <= S_DIFF;
                end
                S_DIFF:
                begin
                    d_reg     <= diff_w[30:0];
                    zero_reg  <= ($unsigned(diff_w) > EXP_LIMIT);
                    state_reg <= S_U;
                end
                S_U:
                begin
                    u_reg     <= 31'((62'(d_reg) * 62'(LOG2E_Q30)) >> 30);
                    state_reg <= S_X;
                end
                S_X:
                begin
                    k_reg    <= 7'(u_reg >> FRAC_BITS);
                    x_reg    <= 30'((60'(f30_w) * 60'(LN2_Q30)) >> 30);
                    tsum_reg <= Q30_ONE;
                    term_reg <= Q30_ONE;
                    n_reg    <= 4'd1;
                    if (zero_reg)
                    begin
                        e_reg     <= '0;
                        state_reg <= S_W;
                    end
                    else
                    begin
                        state_reg <= S_T1;
                    end
                end
                S_T1:
                begin
                    tprod_reg <= 30'((61'(term_reg) * 61'(x_reg)) >> 30);
                    state_reg <= S_T2;
                end
                S_T2:
                begin
                    term_reg  <= 31'((65'(tprod_reg) * 65'(exp_recip(n_reg))) >> RECIP_SHIFT);
                    state_reg <= S_T3;
                end
                S_T3:
                begin
                    tsum_reg  <= n_reg[0] ? (tsum_reg - term_reg) : (tsum_reg + term_reg);
                    n_reg     <= n_reg + 4'd1;
                    state_reg <= (n_reg == 4'd12) ? S_SH : S_T1;
                end
                S_SH:
                begin
                    // Shifts of 32 or more leave nothing of a sum below 2^31.
                    e_reg     <= (sh_w >= 8'd32) ? '0 : E_W'(sh_sum_w >> sh_w);
                    state_reg <= S_W;
                end
                S_W:
                begin
                    wprod_reg <= 33'((65'(rd_wt) * 65'(e_reg)) >> FRAC_BITS);
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    acc_reg   <= acc_reg + ACC_W'(wprod_reg);
                    state_reg <= (rd_ptr_reg == cnt_reg) ? S_LCHK : S_RD;
                end
                S_LCHK:
                begin
                    norm_reg   <= acc_reg;
                    shifts_reg <= '0;
                    if (acc_reg == '0)
                    begin
                        zero_sum_reg <= 1'b1;
                        res_reg      <= '0;
                        state_reg    <= S_FIN;
                    end
                    else
                    begin
                        zero_sum_reg <= 1'b0;
                        state_reg    <= S_NORM;
                    end
                end
                S_NORM:
                begin
                    // One bit a cycle until the leading one reaches the top.
                    if (norm_reg[ACC_W-1])
                    begin
                        state_reg <= S_DIVINIT;
                    end
                    else
                    begin
                        norm_reg   <= norm_reg << 1;
                        shifts_reg <= shifts_reg + SH_W'(1);
                    end
                end
                S_DIVINIT:
                begin
                    den_reg   <= 32'(m_w) + 32'(Q30_ONE);
                    rem_reg   <= 32'(mdiff_w >> 1);
                    nlow_reg  <= {mdiff_w[0], 30'b0};
                    quot_reg  <= '0;
                    dcnt_reg  <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    // Restoring division, one quotient bit a cycle.
                    if (rem2_w >= {1'b0, den_reg})
                    begin
                        rem_reg  <= 32'(rem2_w - {1'b0, den_reg});
                        quot_reg <= {quot_reg[29:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= rem2_w[31:0];
                        quot_reg <= {quot_reg[29:0], 1'b0};
                    end
                    nlow_reg  <= nlow_reg << 1;
                    dcnt_reg  <= dcnt_reg + 5'd1;
                    state_reg <= (dcnt_reg == 5'd30) ? S_Z2 : S_DIV;
                end
                S_Z2:
                begin
                    z2_reg    <= 30'((60'(quot_reg[29:0]) * 60'(quot_reg[29:0])) >> 30);
                    pw_reg    <= quot_reg[29:0];
                    accl_reg  <= '0;
                    lk_reg    <= '0;
                    state_reg <= S_LK1;
                end
                S_LK1:
                begin
                    lq_reg    <= 30'((65'(pw_reg) * 65'(ln_recip(lk_reg))) >> RECIP_SHIFT);
                    pw_reg    <= 30'((60'(pw_reg) * 60'(z2_reg)) >> 30);
                    state_reg <= S_LK2;
                end
                S_LK2:
                begin
                    accl_reg  <= accl_reg + 32'(lq_reg);
                    lk_reg    <= lk_reg + 4'd1;
                    state_reg <= (lk_reg == 4'd14) ? S_V : S_LK1;
                end
                S_V:
                begin
                    v_reg     <= vprod_w + $signed({7'b0, accl_reg, 1'b0});
                    state_reg <= S_R;
                end
                S_R:
                begin
                    // Saturate to the signed 32-bit range.
                    if (res_w > 40'sd2147483647)
                    begin
                        res_reg <= 32'sh7FFF_FFFF;
                    end
                    else if (res_w < -40'sd2147483648)
                    begin
                        res_reg <= 32'sh8000_0000;
                    end
                    else
                    begin
                        res_reg <= res_w[31:0];
                    end
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (!result_valid_reg || result_ready)
                    begin
                        result_valid_reg <= 1'b1;
                        log_sum_reg      <= res_reg;
                        status_reg       <= ovf_reg ? STAT_OVERFLOW
                                          : (zero_sum_reg ? STAT_SUM_ZERO : STAT_OK);
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // The read pointer never runs past the job's element count.
    a_rd_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (rd_ptr_reg <= cnt_reg))
        else $error("read pointer beyond element count");

    // While a job is running, the front end only overwrites entries already read.
    a_write_safe: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && (state_reg != S_IDLE)) |-> (CNT_W'(wr_addr) < rd_ptr_reg))
        else $error("store entry overwritten before it was read");

    // The divider only starts on a normalised sum.
    a_norm_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIVINIT) |-> norm_reg[ACC_W-1])
        else $error("sum not normalised before division");

    // A waiting result is never replaced before it is taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && !result_ready) |=> (result_valid_reg && $stable(log_sum_reg)))
        else $error("pending result lost");
`endif

endmodule

[design/weighted_log_sum_exp_top.sv]
// Loading: one item per cycle into the vector store; items wait while the job queue is
// full or the back end has not yet read the slots they would overwrite. Back end: per
// stored element, an exponential (skipped when it lies far below the maximum) and a
// weighted add, then the logarithm (normalise, divide, atanh series).
// Reset (rst_n, asynchronous, active low) empties the job queue and the result register;
// store contents are undefined until written and are never read before that.
module weighted_log_sum_exp_top
    import wlse_pkg::*;
#(
    parameter int DEPTH     = 1024,
    parameter int FRAC_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  logic signed [31:0]  value,
    input  logic [31:0]         weight,
    input  logic                last,
    output logic                result_valid,
    input  logic                result_ready,
    output logic signed [31:0]  log_sum,
    output logic [1:0]          status
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int JOB_W = CNT_W + 33;

    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [63:0]      wr_data;
    logic             push;
    logic [JOB_W-1:0] push_data;
    logic             pop;
    logic [JOB_W-1:0] pop_data;
    logic             q_full;
    logic             q_empty;
    logic             back_idle;
    logic [CNT_W-1:0] rd_ptr;

    // Front end: loads the vector and tracks the maximum.
    wlse_front #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CNT_W (CNT_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .value      (value),
        .weight     (weight),
        .last       (last),
        .q_full     (q_full),
        .q_empty    (q_empty),
        .back_idle  (back_idle),
        .rd_ptr     (rd_ptr),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .push       (push),
        .push_data  (push_data)
    );

    // Job queue between the two halves.
    wlse_queue #(
        .W (JOB_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    // Back end: weighted exponential sum and logarithm.
    wlse_back #(
        .DEPTH     (DEPTH),
        .FRAC_BITS (FRAC_BITS),
        .AW        (AW),
        .CNT_W     (CNT_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .q_empty      (q_empty),
        .job_data     (pop_data),
        .pop          (pop),
        .back_idle    (back_idle),
        .rd_ptr       (rd_ptr),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .log_sum      (log_sum),
        .status       (status)
    );

endmodule
